FILE: rtl/vfpdec_pkg.sv
`timescale 1ns / 1ps

package vfpdec_pkg;

  // operation codes
  typedef logic [3:0] op_t;
  localparam op_t OP_MOV    = 4'd0;
  localparam op_t OP_MOVIMM = 4'd1;
  localparam op_t OP_ADD    = 4'd2;
  localparam op_t OP_SUB    = 4'd3;
  localparam op_t OP_DIV    = 4'd4;
  localparam op_t OP_MUL    = 4'd5;
  localparam op_t OP_NMUL   = 4'd6;
  localparam op_t OP_MLA    = 4'd7;
  localparam op_t OP_NMLA   = 4'd8;
  localparam op_t OP_MLS    = 4'd9;
  localparam op_t OP_NMLS   = 4'd10;
  localparam op_t OP_ABS    = 4'd11;
  localparam op_t OP_NEG    = 4'd12;
  localparam op_t OP_SQRT   = 4'd13;

  typedef logic [4:0] reg_num_t;

  // fixed bits of a vfp data-processing word
  localparam logic [31:0] FIXED_MASK  = 32'h0F00_0E10;
  localparam logic [31:0] FIXED_MATCH = 32'h0E00_0A00;

  // opc1 as {bit 23, bit 21, bit 20}
  typedef logic [2:0] opc1_t;
  localparam opc1_t OPC1_MLA  = 3'b000;
  localparam opc1_t OPC1_NMLS = 3'b001;
  localparam opc1_t OPC1_MUL  = 3'b010;
  localparam opc1_t OPC1_ADD  = 3'b011;
  localparam opc1_t OPC1_DIV  = 3'b100;
  localparam opc1_t OPC1_SPC  = 3'b111;

  // opc2 codes under the special opc1
  localparam logic [3:0] OPC2_MOV_ABS  = 4'd0;
  localparam logic [3:0] OPC2_NEG_SQRT = 4'd1;

  // one decoded result item
  typedef struct packed {
    logic        valid_res;
    op_t         operation;
    logic        is_double;
    reg_num_t    dest_reg;
    reg_num_t    first_src_reg;
    reg_num_t    second_src_reg;
    logic [63:0] immediate_bits;
    logic        reads_dest;
    logic        reads_first;
    logic        reads_second;
    logic        has_immediate;
  } res_t;

endpackage

FILE: rtl/vfp_data_op_decoder_top.sv
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_stall   | in_instruction_word
// out_    | output    | out_valid / out_stall | out_valid_res .. out_has_immediate
//
// one item per cycle while out_stall is low; an item passes the input register,
// then the result register after one level of decode logic.
// rst_n is synchronous, active low, and empties both register stages.
// a stalled result holds; an empty input register still takes an item while the
// result register waits, and in_stall rises only when both stages are full.

module vfp_data_op_decoder_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_instruction_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_valid_res,
  output vfpdec_pkg::op_t       out_operation,
  output logic                  out_is_double,
  output vfpdec_pkg::reg_num_t  out_dest_reg,
  output vfpdec_pkg::reg_num_t  out_first_src_reg,
  output vfpdec_pkg::reg_num_t  out_second_src_reg,
  output logic [63:0]           out_immediate_bits,
  output logic                  out_reads_dest,
  output logic                  out_reads_first,
  output logic                  out_reads_second,
  output logic                  out_has_immediate
);
  import vfpdec_pkg::*;

  logic        word_vld_r;
  logic [31:0] word_r;
  logic        res_vld_r;
  res_t        res_r;
  res_t        res_nxt;
  logic        adv_res;
  logic        adv_in;

  // pipeline flow control
  assign adv_res  = !res_vld_r || !out_stall;
  assign adv_in   = !word_vld_r || adv_res;
  assign in_stall = !adv_in;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_vld_r <= 1'b0;
    end else if (adv_in) begin
      word_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      word_r <= in_instruction_word;
    end
  end

  // decode
  always_comb begin
    logic     fixed_ok;
    logic     ok;
    op_t      op;
    opc1_t    opc1;
    logic [3:0] opc2;
    logic     b6;
    logic     b7;
    logic     dbl;
    logic     use_d;
    logic     use_n;
    logic     use_m;
    logic     use_imm;
    logic     ia;
    logic     ib;
    logic [1:0] icd;
    logic [3:0] ilo;

    fixed_ok = (word_r & FIXED_MASK) == FIXED_MATCH;
    opc1     = {word_r[23], word_r[21], word_r[20]};
    opc2     = word_r[19:16];
    b6       = word_r[6];
    b7       = word_r[7];
    dbl      = word_r[8];
    ok       = 1'b1;
    op       = OP_MOV;

    // operation from opc1, opc2 and bits 7, 6
    unique case (opc1)
      OPC1_MLA:  op = b6 ? OP_MLS  : OP_MLA;
      OPC1_NMLS: op = b6 ? OP_NMLA : OP_NMLS;
      OPC1_MUL:  op = b6 ? OP_NMUL : OP_MUL;
      OPC1_ADD:  op = b6 ? OP_SUB  : OP_ADD;
      OPC1_DIV: begin
        op = OP_DIV;
        ok = !b6;
      end
      OPC1_SPC: begin
        if (!b6) begin
          op = OP_MOVIMM;
        end else if (opc2 == OPC2_MOV_ABS) begin
          op = b7 ? OP_ABS : OP_MOV;
        end else if (opc2 == OPC2_NEG_SQRT) begin
          op = b7 ? OP_SQRT : OP_NEG;
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase
    ok = ok && fixed_ok;

    // operand usage per operation
    use_d   = 1'b0;
    use_n   = 1'b0;
    use_m   = 1'b0;
    use_imm = 1'b0;
    unique case (op) inside
      OP_MLA, OP_NMLA, OP_MLS, OP_NMLS: begin
        use_d = 1'b1;
        use_n = 1'b1;
        use_m = 1'b1;
      end
      OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_NMUL: begin
        use_n = 1'b1;
        use_m = 1'b1;
      end
      OP_MOVIMM: use_imm = 1'b1;
      default:   use_m = 1'b1;
    endcase

    // immediate fields a, b, cd, efgh
    ia  = word_r[19];
    ib  = word_r[18];
    icd = word_r[17:16];
    ilo = word_r[3:0];

    res_nxt = '0;
    if (ok) begin
      res_nxt.valid_res = 1'b1;
      res_nxt.operation = op;
      res_nxt.is_double = dbl;
      res_nxt.dest_reg  = dbl ? {word_r[22], word_r[15:12]} : {word_r[15:12], word_r[22]};
      if (use_n) begin
        res_nxt.first_src_reg = dbl ? {word_r[7], word_r[19:16]} : {word_r[19:16], word_r[7]};
      end
      if (use_m) begin
        res_nxt.second_src_reg = dbl ? {word_r[5], word_r[3:0]} : {word_r[3:0], word_r[5]};
      end
      if (use_imm) begin
        if (dbl) begin
          res_nxt.immediate_bits = {ia, !ib, {8{ib}}, icd, ilo, 48'd0};
        end else begin
          res_nxt.immediate_bits = {32'd0, ia, !ib, {5{ib}}, icd, ilo, 19'd0};
        end
      end
      res_nxt.reads_dest    = use_d;
      res_nxt.reads_first   = use_n;
      res_nxt.reads_second  = use_m;
      res_nxt.has_immediate = use_imm;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv_res) begin
      res_vld_r <= word_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_res && word_vld_r) begin
      res_r <= res_nxt;
    end
  end

  // outputs
  assign out_valid          = res_vld_r;
  assign out_valid_res      = res_r.valid_res;
  assign out_operation      = res_r.operation;
  assign out_is_double      = res_r.is_double;
  assign out_dest_reg       = res_r.dest_reg;
  assign out_first_src_reg  = res_r.first_src_reg;
  assign out_second_src_reg = res_r.second_src_reg;
  assign out_immediate_bits = res_r.immediate_bits;
  assign out_reads_dest     = res_r.reads_dest;
  assign out_reads_first    = res_r.reads_first;
  assign out_reads_second   = res_r.reads_second;
  assign out_has_immediate  = res_r.has_immediate;

endmodule

FILE: rtl/vfpdec_checker.sv
`timescale 1ns / 1ps

module vfpdec_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_valid_res,
  input vfpdec_pkg::op_t      out_operation,
  input logic                 out_is_double,
  input vfpdec_pkg::reg_num_t out_dest_reg,
  input vfpdec_pkg::reg_num_t out_first_src_reg,
  input vfpdec_pkg::reg_num_t out_second_src_reg,
  input logic [63:0]          out_immediate_bits,
  input logic                 out_reads_dest,
  input logic                 out_reads_first,
  input logic                 out_reads_second,
  input logic                 out_has_immediate
);
  import vfpdec_pkg::*;

  // a stalled result item stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item offered after reset");

  // an unsupported word gives an all-zero item
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_operation == OP_MOV && !out_is_double
      && out_dest_reg == '0 && out_first_src_reg == '0 && out_second_src_reg == '0
      && out_immediate_bits == '0 && !out_reads_dest && !out_reads_first
      && !out_reads_second && !out_has_immediate)
    else $error("invalid item carries nonzero fields");

  // a valid op takes either registers or the immediate, never both
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> (out_reads_second != out_has_immediate)
      && (out_has_immediate == (out_operation == OP_MOVIMM)))
    else $error("operand usage does not match operation");

  // accumulator forms also read the first source; unread sources are zero
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> (!out_reads_dest || out_reads_first)
      && (out_reads_first || out_first_src_reg == '0)
      && (!out_has_immediate || out_second_src_reg == '0))
    else $error("source fields inconsistent with usage flags");

endmodule

bind vfp_data_op_decoder_top vfpdec_checker u_vfpdec_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_valid_res      (out_valid_res),
  .out_operation      (out_operation),
  .out_is_double      (out_is_double),
  .out_dest_reg       (out_dest_reg),
  .out_first_src_reg  (out_first_src_reg),
  .out_second_src_reg (out_second_src_reg),
  .out_immediate_bits (out_immediate_bits),
  .out_reads_dest     (out_reads_dest),
  .out_reads_first    (out_reads_first),
  .out_reads_second   (out_reads_second),
  .out_has_immediate  (out_has_immediate)
);
